/* hw/rtl/audio_gain_ramp_fader_top_defines.svh */
// Assertion macros for the gain ramp fader.
// Included by audio_gain_ramp_fader_top.sv; depends on nothing else.
`ifndef AUDIO_GAIN_RAMP_FADER_TOP_DEFINES_SVH
`define AUDIO_GAIN_RAMP_FADER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define AGRF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("agrf: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define AGRF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("agrf: next-cycle check failed");

`endif

/* hw/rtl/agrf_pkg.sv */
// Shared constants and types of the gain ramp fader.
// Used by agrf_ctrl, agrf_dp and audio_gain_ramp_fader_top; no dependencies.
package agrf_pkg;

   localparam int LENGTH_BITS_DEF = 24;
   localparam int GAIN_FRAC_BITS  = 9;
   localparam int GAIN_BITS       = 13;
   localparam int CFG_GAIN_BITS   = 11;
   localparam int SAMPLE_BITS     = 16;
   localparam int CSR_INDEX_BITS  = 2;

   localparam logic signed [SAMPLE_BITS-1:0] SAT_MAX = 16'sd32767;
   localparam logic signed [SAMPLE_BITS-1:0] SAT_MIN = -16'sd32767;

   localparam logic [CSR_INDEX_BITS-1:0] REG_START_GAIN    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_END_GAIN      = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_REGION_LENGTH = 2'd2;

   typedef struct packed {
      logic accept_plain;  // scale the incoming item with the running ramp
      logic start_div;     // latch the restart item, load the divider
      logic div_step;      // one quotient bit
      logic finish;        // reload ramp from quotient, scale the held item
   } ctrl_cmd_type;

endpackage

/* hw/rtl/agrf_ctrl.sv */
// Controller of the gain ramp fader: handshakes, divider sequencing.
// Depends on agrf_pkg.
module agrf_ctrl #(
   parameter int LENGTH_BITS = agrf_pkg::LENGTH_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_restart,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output agrf_pkg::ctrl_cmd_type cmd
);

   localparam int CntBits = (LENGTH_BITS > 1) ? $clog2(LENGTH_BITS) : 1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_FIN  = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [CntBits-1:0] cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = slot_free;
            if (req_valid && slot_free) begin
               if (req_restart) begin
                  cmd.start_div = 1'b1;
                  cnt_in        = '0;
                  state_in      = ST_DIV;
               end else begin
                  cmd.accept_plain = 1'b1;
                  rsp_valid_in     = 1'b1;
               end
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CntBits'(1);
            if (cnt_ff == CntBits'(LENGTH_BITS - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (slot_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* hw/rtl/agrf_dp.sv */
// Datapath of the gain ramp fader: registers, ramp state, divider, scaler.
// Depends on agrf_pkg; driven by agrf_ctrl commands.
module agrf_dp #(
   parameter  int LENGTH_BITS = agrf_pkg::LENGTH_BITS_DEF,
   localparam int CsrBits     = (LENGTH_BITS > agrf_pkg::CFG_GAIN_BITS) ?
                                LENGTH_BITS : agrf_pkg::CFG_GAIN_BITS
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  agrf_pkg::ctrl_cmd_type                   cmd,
   input  logic                                     csr_we,
   input  logic [agrf_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [CsrBits-1:0]                       csr_wdata,
   input  logic signed [agrf_pkg::SAMPLE_BITS-1:0]  req_sample_in,
   output logic signed [agrf_pkg::SAMPLE_BITS-1:0]  rsp_sample_out
);

   localparam int GW   = agrf_pkg::GAIN_BITS;
   localparam int CW   = agrf_pkg::CFG_GAIN_BITS;
   localparam int SW   = agrf_pkg::SAMPLE_BITS;
   localparam int PW   = SW + GW;
   localparam int FRAC = agrf_pkg::GAIN_FRAC_BITS;

   logic [CW-1:0]          start_ff, end_ff;
   logic [LENGTH_BITS-1:0] region_ff;

   logic signed [GW-1:0]   gain_ff, gain_in;
   logic [LENGTH_BITS-1:0] steps_ff, steps_in;
   logic [LENGTH_BITS-1:0] interval_ff;
   logic                   down_ff;

   logic signed [SW-1:0]   hold_ff;
   logic [CW:0]            mag_ff;
   logic                   neg_ff;
   logic [CW-1:0]          rem_ff, rem_in;
   logic [LENGTH_BITS-1:0] quot_ff, quot_in;
   logic signed [SW-1:0]   out_ff, out_in;

   // divisor = end - start + 1, magnitude, zero forced to one
   logic [GW-1:0] diff;
   logic [GW-1:0] diff_abs;
   logic [CW:0]   mag_new;
   logic [CW:0]   trial;
   logic          trial_ge;

   assign diff     = GW'(end_ff) - GW'(start_ff) + GW'(1);
   assign diff_abs = diff[GW-1] ? (~diff + GW'(1)) : diff;
   assign mag_new  = (diff_abs == '0) ? (CW+1)'(1) : diff_abs[CW:0];

   assign trial    = {rem_ff, quot_ff[LENGTH_BITS-1]};
   assign trial_ge = trial >= mag_ff;

   always_comb begin
      rem_in  = rem_ff;
      quot_in = quot_ff;
      if (cmd.start_div) begin
         rem_in  = '0;
         quot_in = region_ff;
      end else if (cmd.div_step) begin
         rem_in  = trial_ge ? CW'(trial - mag_ff) : trial[CW-1:0];
         quot_in = {quot_ff[LENGTH_BITS-2:0], trial_ge};
      end
   end

   // scale and ramp advance
   logic signed [GW-1:0]   gain_src;
   logic signed [SW-1:0]   sample_src;
   logic [LENGTH_BITS-1:0] steps_src;
   logic [LENGTH_BITS-1:0] interval_src;
   logic                   down_src;
   logic signed [PW-1:0]   prod;
   logic signed [PW-FRAC-1:0] scaled;

   always_comb begin
      gain_src     = cmd.finish ? $signed(GW'(start_ff)) : gain_ff;
      sample_src   = cmd.finish ? hold_ff : req_sample_in;
      steps_src    = cmd.finish ? quot_ff : steps_ff;
      interval_src = cmd.finish ? quot_ff : interval_ff;
      down_src     = cmd.finish ? (neg_ff && (quot_ff != '0)) : down_ff;

      prod   = PW'(sample_src) * PW'(gain_src);
      scaled = prod[PW-1:FRAC];
      if (scaled > (PW-FRAC)'(agrf_pkg::SAT_MAX)) begin
         out_in = agrf_pkg::SAT_MAX;
      end else if (scaled < (PW-FRAC)'(agrf_pkg::SAT_MIN)) begin
         out_in = agrf_pkg::SAT_MIN;
      end else begin
         out_in = scaled[SW-1:0];
      end

      if (steps_src <= LENGTH_BITS'(1)) begin
         steps_in = interval_src;
         gain_in  = down_src ? gain_src - GW'(1) : gain_src + GW'(1);
      end else begin
         steps_in = steps_src - LENGTH_BITS'(1);
         gain_in  = gain_src;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff    <= '0;
         end_ff      <= CW'(512);
         region_ff   <= '0;
         gain_ff     <= '0;
         steps_ff    <= '0;
         interval_ff <= '0;
         down_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               agrf_pkg::REG_START_GAIN:    start_ff  <= csr_wdata[CW-1:0];
               agrf_pkg::REG_END_GAIN:      end_ff    <= csr_wdata[CW-1:0];
               agrf_pkg::REG_REGION_LENGTH: region_ff <= csr_wdata[LENGTH_BITS-1:0];
               default: ;
            endcase
         end
         if (cmd.accept_plain || cmd.finish) begin
            gain_ff     <= gain_in;
            steps_ff    <= steps_in;
            interval_ff <= interval_src;
            down_ff     <= down_src;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_div) begin
         hold_ff <= req_sample_in;
         mag_ff  <= mag_new;
         neg_ff  <= diff[GW-1];
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      if (cmd.accept_plain || cmd.finish) begin
         out_ff <= out_in;
      end
   end

   assign rsp_sample_out = out_ff;

endmodule

/* hw/rtl/audio_gain_ramp_fader_top.sv */
// Channel   | Ports                                            | Direction
// req       | req_valid, req_ready, req_sample_in, req_restart | in
// rsp       | rsp_valid, rsp_ready, rsp_sample_out             | out
// csr       | csr_valid, csr_ready, csr_index, csr_wdata       | in (write only)
// A plain item is answered in the cycle after it is accepted; items follow back to back while rsp drains.
// A restart item goes through a bit-serial divider that yields one quotient bit
// per cycle; then the ramp reloads and the held item is scaled.
// Reset is synchronous; no clearing pass. A stalled rsp holds off new items.
// Depends on agrf_pkg, agrf_ctrl, agrf_dp and the assertion macro header.
`include "audio_gain_ramp_fader_top_defines.svh"

module audio_gain_ramp_fader_top #(
   parameter  int LENGTH_BITS = agrf_pkg::LENGTH_BITS_DEF,
   localparam int CsrBits     = (LENGTH_BITS > agrf_pkg::CFG_GAIN_BITS) ?
                                LENGTH_BITS : agrf_pkg::CFG_GAIN_BITS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [agrf_pkg::SAMPLE_BITS-1:0] req_sample_in,
   input  logic                                    req_restart,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [agrf_pkg::SAMPLE_BITS-1:0] rsp_sample_out,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [agrf_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CsrBits-1:0]                      csr_wdata
);

   agrf_pkg::ctrl_cmd_type cmd;

   assign csr_ready = 1'b1;

   agrf_ctrl #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_restart(req_restart),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .cmd        (cmd)
   );

   agrf_dp #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .csr_we        (csr_valid && csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_sample_in (req_sample_in),
      .rsp_sample_out(rsp_sample_out)
   );

   `AGRF_ASSERT_NEXT(a_restart_blocks, clock, reset, req_valid && req_ready && req_restart, !req_ready)
   `AGRF_ASSERT_NOW(a_no_overwrite, clock, reset, req_valid && req_ready, !rsp_valid || rsp_ready)
   `AGRF_ASSERT_NOW(a_symmetric_sat, clock, reset, rsp_valid, rsp_sample_out != 16'sh8000)

endmodule
